### rtl/pip_pkg.sv
package pip_pkg;

  localparam int MaxVertices = 64;
  localparam int CoordBits   = 24;
  localparam int AddrBits    = $clog2(MaxVertices);
  localparam int CountBits   = $clog2(MaxVertices + 1);
  localparam int DiffBits    = 32;
  localparam int ProdBits    = 2 * DiffBits;
  localparam int NumProds    = 8;

  localparam logic signed [DiffBits-1:0] FarOriginY = DiffBits'(1 << 30);

  localparam logic [1:0] CmdClear  = 2'd0;
  localparam logic [1:0] CmdAppend = 2'd1;
  localparam logic [1:0] CmdQuery  = 2'd2;

  typedef struct packed {
    logic [1:0]                  command;
    logic signed [CoordBits-1:0] coord_x;
    logic signed [CoordBits-1:0] coord_y;
  } pip_in_t;

  typedef struct packed {
    logic                 inside_res;
    logic [CountBits-1:0] vertices_held;
  } pip_out_t;

  typedef struct packed {
    logic                 wr_en;
    logic [AddrBits-1:0]  wr_addr;
    logic                 rd_en;
    logic [AddrBits-1:0]  rd_addr;
    logic                 first;
    logic                 close;
    logic                 start;
    logic                 load_out;
    logic [CountBits-1:0] count;
  } pip_cmd_t;

  typedef struct packed {
    logic busy;
  } pip_sts_t;

endpackage

### rtl/pip_ram.sv
module pip_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [Width-1:0]    wdata_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/pip_ctrl.sv
module pip_ctrl import pip_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output pip_cmd_t   cmd_o,
  input  pip_sts_t   sts_i
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRead  = 2'd1;
  localparam logic [1:0] StClose = 2'd2;
  localparam logic [1:0] StDrain = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [CountBits-1:0] count_q, count_d;
  logic [AddrBits-1:0]  addr_q, addr_d;
  logic                 out_valid_q, out_valid_d;
  logic                 accept;
  logic                 last_read;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);
  assign last_read  = (CountBits'(addr_q) + CountBits'(1)) == count_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    addr_d      = addr_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.count   = count_q;
    cmd_o.wr_addr = count_q[AddrBits-1:0];
    cmd_o.rd_addr = addr_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          case (command_i)
            CmdClear: begin
              count_d = '0;
            end
            CmdAppend: begin
              if (count_q < CountBits'(MaxVertices)) begin
                cmd_o.wr_en = 1'b1;
                count_d     = count_q + CountBits'(1);
              end
            end
            CmdQuery: begin
              cmd_o.start = 1'b1;
              addr_d      = '0;
              state_d     = (count_q == '0) ? StDrain : StRead;
            end
            default: begin
            end
          endcase
        end
      end
      StRead: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.first = (addr_q == '0);
        if (last_read) begin
          state_d = StClose;
        end else begin
          addr_d = addr_q + AddrBits'(1);
        end
      end
      StClose: begin
        cmd_o.close = 1'b1;
        state_d     = StDrain;
      end
      StDrain: begin
        if (!sts_i.busy && (!out_valid_q || !out_stall_i)) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      addr_q      <= addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/pip_dp.sv
module pip_dp import pip_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  pip_cmd_t cmd_i,
  input  pip_in_t  in_data_i,
  output pip_sts_t sts_o,
  output pip_out_t out_data_o
);

  logic [2*CoordBits-1:0] rd_data;
  logic signed [CoordBits-1:0] rd_x, rd_y;

  logic rd_vld_q, first_q, close_q;
  logic edge_vld_q, op_vld_q, prod_vld_q;
  logic parity_q;

  logic signed [CoordBits-1:0] px_q, py_q;
  logic signed [CoordBits-1:0] prev_x_q, prev_y_q, first_x_q, first_y_q;
  logic signed [CoordBits-1:0] s1x_q, s1y_q, s2x_q, s2y_q;
  logic                        edge_d;

  logic signed [DiffBits-1:0] s1x, s1y, s2x, s2y, px, py;
  logic signed [DiffBits-1:0] opa_d [NumProds];
  logic signed [DiffBits-1:0] opb_d [NumProds];
  logic signed [DiffBits-1:0] opa_q [NumProds];
  logic signed [DiffBits-1:0] opb_q [NumProds];
  logic signed [ProdBits-1:0] prod_q [NumProds];
  logic [3:0]                 orient;
  logic                       crossing;

  pip_out_t out_q;

  pip_ram #(
    .Width (2 * CoordBits),
    .Depth (MaxVertices)
  ) u_vertex_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (cmd_i.wr_addr),
    .wdata_i ({in_data_i.coord_x, in_data_i.coord_y}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (rd_data)
  );

  assign rd_x   = signed'(rd_data[2*CoordBits-1:CoordBits]);
  assign rd_y   = signed'(rd_data[CoordBits-1:0]);
  assign edge_d = (rd_vld_q && !first_q) || close_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      first_q    <= 1'b0;
      close_q    <= 1'b0;
      edge_vld_q <= 1'b0;
      op_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      parity_q   <= 1'b0;
    end else begin
      rd_vld_q   <= cmd_i.rd_en;
      first_q    <= cmd_i.rd_en && cmd_i.first;
      close_q    <= cmd_i.close;
      edge_vld_q <= edge_d;
      op_vld_q   <= edge_vld_q;
      prod_vld_q <= op_vld_q;
      if (cmd_i.start) begin
        parity_q <= 1'b0;
      end else if (prod_vld_q && crossing) begin
        parity_q <= !parity_q;
      end
    end
  end

  // The edge operands come from the previous vertex and either the vertex
  // just read or, for the closing edge, the first vertex of the polygon.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_q <= in_data_i.coord_x;
      py_q <= in_data_i.coord_y;
    end
    if (rd_vld_q) begin
      prev_x_q <= rd_x;
      prev_y_q <= rd_y;
    end
    if (first_q) begin
      first_x_q <= rd_x;
      first_y_q <= rd_y;
    end
    if (edge_d) begin
      s1x_q <= prev_x_q;
      s1y_q <= prev_y_q;
      s2x_q <= close_q ? first_x_q : rd_x;
      s2y_q <= close_q ? first_y_q : rd_y;
    end
    if (cmd_i.load_out) begin
      out_q.inside_res    <= parity_q;
      out_q.vertices_held <= cmd_i.count;
    end
  end

  assign s1x = DiffBits'(s1x_q);
  assign s1y = DiffBits'(s1y_q);
  assign s2x = DiffBits'(s2x_q);
  assign s2y = DiffBits'(s2y_q);
  assign px  = DiffBits'(px_q);
  assign py  = DiffBits'(py_q);

  // Each orientation test compares the even product against the odd one.
  always_comb begin
    opa_d[0] = s2y - FarOriginY;  opb_d[0] = s1x;
    opa_d[1] = s1y - FarOriginY;  opb_d[1] = s2x;
    opa_d[2] = s2y - py;          opb_d[2] = s1x - px;
    opa_d[3] = s1y - py;          opb_d[3] = s2x - px;
    opa_d[4] = s1y - FarOriginY;  opb_d[4] = px;
    opa_d[5] = py - FarOriginY;   opb_d[5] = s1x;
    opa_d[6] = s2y - FarOriginY;  opb_d[6] = px;
    opa_d[7] = py - FarOriginY;   opb_d[7] = s2x;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumProds; k++) begin
      opa_q[k]  <= opa_d[k];
      opb_q[k]  <= opb_d[k];
      prod_q[k] <= ProdBits'(opa_q[k]) * ProdBits'(opb_q[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      orient[k] = prod_q[2*k] >= prod_q[2*k+1];
    end
  end

  assign crossing = (orient[0] != orient[1]) && (orient[2] != orient[3]);

  assign sts_o.busy = rd_vld_q || close_q || edge_vld_q || op_vld_q || prod_vld_q;
  assign out_data_o = out_q;

endmodule

### rtl/point_in_polygon_test.sv
// Clear and append beats produce no result beat.
// A query over n >= 1 stored vertices reads the vertex memory one vertex per cycle,
// adds one closing edge, then lets a four-stage edge pipeline drain before its result
// beat is raised; an empty polygon answers without any vertex memory read.
// Input stalls until the result beat appears.
// Reset empties the polygon and drops any pending result; vertex memory is not cleared.
module point_in_polygon_test import pip_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pip_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pip_out_t out_data_o
);

  pip_cmd_t cmd;
  pip_sts_t sts;

  pip_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (in_data_i.command),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  pip_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
